[rtl/gpbc_pkg.sv]
// Shared types, constants and binomial table for the Gaussian product
// expansion coefficient core. No dependencies.
`timescale 1ns / 1ps

package gpbc_pkg;

  localparam int unsigned MAX_MOMENTUM = 6;

  localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [63:0] DBL_DNAN = 64'hFFF8_0000_0000_0000;

  typedef enum logic {
    FOP_MUL,
    FOP_ADD
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

  typedef struct packed {
    logic done;
  } fpu_rsp_t;

  // Exact binomial coefficient C(n, k) for n up to MAX_MOMENTUM.
  function automatic logic [4:0] binom_val(input logic [2:0] n, input logic [2:0] k);
    logic [4:0] r;
    r = 5'd0;
    if (k <= n) begin
      case (n)
        3'd0, 3'd1: r = 5'd1;
        3'd2: r = (k == 3'd1) ? 5'd2 : 5'd1;
        3'd3: r = (k == 3'd1 || k == 3'd2) ? 5'd3 : 5'd1;
        3'd4: begin
          case (k)
            3'd1, 3'd3: r = 5'd4;
            3'd2: r = 5'd6;
            default: r = 5'd1;
          endcase
        end
        3'd5: begin
          case (k)
            3'd1, 3'd4: r = 5'd5;
            3'd2, 3'd3: r = 5'd10;
            default: r = 5'd1;
          endcase
        end
        3'd6: begin
          case (k)
            3'd1, 3'd5: r = 5'd6;
            3'd2, 3'd4: r = 5'd15;
            3'd3: r = 5'd20;
            default: r = 5'd1;
          endcase
        end
        default: r = 5'd1;
      endcase
    end
    return r;
  endfunction

  // Binomial coefficient as a binary64 bit pattern.
  function automatic logic [63:0] binom_dbl(input logic [2:0] n, input logic [2:0] k);
    logic [63:0] d;
    case (binom_val(n, k))
      5'd1:  d = 64'h3FF0_0000_0000_0000;
      5'd2:  d = 64'h4000_0000_0000_0000;
      5'd3:  d = 64'h4008_0000_0000_0000;
      5'd4:  d = 64'h4010_0000_0000_0000;
      5'd5:  d = 64'h4014_0000_0000_0000;
      5'd6:  d = 64'h4018_0000_0000_0000;
      5'd10: d = 64'h4024_0000_0000_0000;
      5'd15: d = 64'h402E_0000_0000_0000;
      5'd20: d = 64'h4034_0000_0000_0000;
      default: d = DBL_ZERO;
    endcase
    return d;
  endfunction

endpackage

[rtl/gpbc_ifc.sv]
// Valid/ready channel interfaces for the input and result beats.
// Depends on nothing.
`timescale 1ns / 1ps

interface gpbc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  order;
  logic [2:0]  momentum_a;
  logic [2:0]  momentum_b;
  logic [63:0] dist_a;
  logic [63:0] dist_b;
  logic        last_axis;

  modport source(output valid, order, momentum_a, momentum_b, dist_a, dist_b, last_axis,
                 input ready);
  modport sink(input valid, order, momentum_a, momentum_b, dist_a, dist_b, last_axis,
               output ready);
endinterface

interface gpbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] axis_coef;
  logic [63:0] running_coef;
  logic        group_done;

  modport source(output valid, axis_coef, running_coef, group_done, input ready);
  modport sink(input valid, axis_coef, running_coef, group_done, output ready);
endinterface

[rtl/gpbc_fpu.sv]
// Iterative binary64 multiply/add unit with round to nearest even.
// Depends on gpbc_pkg.
`timescale 1ns / 1ps

module gpbc_fpu import gpbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fpu_req_t    req,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output fpu_rsp_t    rsp,
  output logic [63:0] result
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_MUL,
    F_NORM,
    F_DONE
  } fstate_t;

  fstate_t       state_r;
  fpu_op_t       op_r;
  logic [63:0]   a_r, b_r;
  logic [63:0]   res_r;
  logic          done_r;
  logic          sign_r;
  logic signed [13:0] exp_r;
  logic [108:0]  m_r;
  logic [52:0]   ma_r, mb_r;
  logic [2:0]    step_r;
  logic [53:0]   pp_r;

  // Operand decode.
  logic        sa, sb;
  logic [10:0] xa, xb, xa_eff, xb_eff;
  logic [51:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [52:0] ma, mb;

  always_comb begin
    sa = a_r[63];
    sb = b_r[63];
    xa = a_r[62:52];
    xb = b_r[62:52];
    fa = a_r[51:0];
    fb = b_r[51:0];
    nan_a  = (xa == 11'h7FF) && (fa != 52'd0);
    nan_b  = (xb == 11'h7FF) && (fb != 52'd0);
    inf_a  = (xa == 11'h7FF) && (fa == 52'd0);
    inf_b  = (xb == 11'h7FF) && (fb == 52'd0);
    zero_a = (a_r[62:0] == 63'd0);
    zero_b = (b_r[62:0] == 63'd0);
    xa_eff = (xa == 11'd0) ? 11'd1 : xa;
    xb_eff = (xb == 11'd0) ? 11'd1 : xb;
    ma = {(xa != 11'd0), fa};
    mb = {(xb != 11'd0), fb};
  end

  // Special-case result.
  logic        special;
  logic [63:0] special_res;

  always_comb begin
    special = 1'b1;
    special_res = DBL_DNAN;
    if (nan_a) begin
      special_res = a_r | 64'h0008_0000_0000_0000;
    end else if (nan_b) begin
      special_res = b_r | 64'h0008_0000_0000_0000;
    end else if (op_r == FOP_MUL) begin
      if ((inf_a && zero_b) || (zero_a && inf_b)) begin
        special_res = DBL_DNAN;
      end else if (inf_a || inf_b) begin
        special_res = {sa ^ sb, 11'h7FF, 52'd0};
      end else if (zero_a || zero_b) begin
        special_res = {sa ^ sb, 63'd0};
      end else begin
        special = 1'b0;
      end
    end else begin
      if (inf_a && inf_b && (sa != sb)) begin
        special_res = DBL_DNAN;
      end else if (inf_a) begin
        special_res = a_r;
      end else if (inf_b) begin
        special_res = b_r;
      end else if (zero_a && zero_b) begin
        special_res = {sa & sb, 63'd0};
      end else if (zero_a) begin
        special_res = b_r;
      end else if (zero_b) begin
        special_res = a_r;
      end else begin
        special = 1'b0;
      end
    end
  end

  // Addition: align the smaller-exponent operand with a sticky bit.
  logic        swap;
  logic [10:0] xbig, dsh;
  logic [52:0] mbig, msml;
  logic        sbig, ssml;
  logic [107:0] sml_full, sml_sh;
  logic        sml_sticky;
  logic [108:0] add_sum, add_dif;
  logic [108:0] add_m;
  logic        add_s;

  always_comb begin
    swap = (xb_eff > xa_eff);
    xbig = swap ? xb_eff : xa_eff;
    mbig = swap ? mb : ma;
    msml = swap ? ma : mb;
    sbig = swap ? sb : sa;
    ssml = swap ? sa : sb;
    dsh  = swap ? (xb_eff - xa_eff) : (xa_eff - xb_eff);
    sml_full = {msml, 55'd0};
    if (dsh >= 11'd108) begin
      sml_sh = 108'd0;
      sml_sticky = |sml_full;
    end else begin
      sml_sh = sml_full >> dsh;
      sml_sticky = |(sml_full & ~({108{1'b1}} << dsh));
    end
    sml_sh[0] = sml_sh[0] | sml_sticky;
    add_sum = {1'b0, mbig, 55'd0} + {1'b0, sml_sh};
    add_dif = {1'b0, mbig, 55'd0} - {1'b0, sml_sh};
    if (sbig == ssml) begin
      add_m = add_sum;
      add_s = sbig;
    end else if (add_dif[108]) begin
      add_m = ~add_dif + 109'd1;
      add_s = ssml;
    end else begin
      add_m = add_dif;
      add_s = sbig;
    end
  end

  // Multiplication: four 27x27 partial products on one multiplier.
  logic [26:0]  mul_x, mul_y;
  logic [107:0] pp_shifted;

  always_comb begin
    case (step_r)
      3'd0: begin mul_x = ma_r[26:0];          mul_y = mb_r[26:0];          end
      3'd1: begin mul_x = ma_r[26:0];          mul_y = {1'b0, mb_r[52:27]}; end
      3'd2: begin mul_x = {1'b0, ma_r[52:27]}; mul_y = mb_r[26:0];          end
      default: begin mul_x = {1'b0, ma_r[52:27]}; mul_y = {1'b0, mb_r[52:27]}; end
    endcase
    case (step_r)
      3'd1: pp_shifted = {54'd0, pp_r};
      3'd2, 3'd3: pp_shifted = {27'd0, pp_r, 27'd0};
      default: pp_shifted = {pp_r, 54'd0};
    endcase
  end

  // Rounding of a normalized mantissa.
  logic [53:0]  rnd_mant;
  logic         rnd_up;
  logic signed [13:0] rnd_exp;
  logic [63:0]  rnd_res;

  always_comb begin
    rnd_up = m_r[54] && ((|m_r[53:0]) || m_r[55]);
    rnd_mant = {1'b0, m_r[107:55]} + {53'd0, rnd_up};
    if (rnd_mant[53]) begin
      rnd_exp = exp_r + 14'sd1;
    end else if (rnd_mant[52]) begin
      rnd_exp = exp_r;
    end else begin
      rnd_exp = 14'sd0;
    end
    if (rnd_exp >= 14'sd2047) begin
      rnd_res = {sign_r, 11'h7FF, 52'd0};
    end else begin
      rnd_res = {sign_r, rnd_exp[10:0], rnd_mant[53] ? 52'd0 : rnd_mant[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        F_IDLE: begin
          if (req.start) begin
            a_r     <= op_a;
            b_r     <= op_b;
            op_r    <= req.op;
            state_r <= F_PREP;
          end
        end
        F_PREP: begin
          if (special) begin
            res_r   <= special_res;
            state_r <= F_DONE;
          end else if (op_r == FOP_MUL) begin
            ma_r    <= ma;
            mb_r    <= mb;
            sign_r  <= sa ^ sb;
            exp_r   <= $signed({3'd0, xa_eff}) + $signed({3'd0, xb_eff}) - 14'sd1022;
            m_r     <= 109'd0;
            step_r  <= 3'd0;
            state_r <= F_MUL;
          end else begin
            m_r     <= add_m;
            sign_r  <= add_s;
            exp_r   <= $signed({3'd0, xbig});
            state_r <= F_NORM;
          end
        end
        F_MUL: begin
          pp_r <= mul_x * mul_y;
          if (step_r != 3'd0) begin
            m_r <= m_r + {1'b0, pp_shifted[105:0], 2'b00};
          end
          if (step_r == 3'd4) begin
            state_r <= F_NORM;
          end
          step_r <= step_r + 3'd1;
        end
        F_NORM: begin
          if (m_r == 109'd0) begin
            res_r   <= DBL_ZERO;
            state_r <= F_DONE;
          end else if (exp_r < -14'sd120) begin
            m_r   <= {108'd0, 1'b1};
            exp_r <= 14'sd1;
          end else if (m_r[108] || exp_r < 14'sd1) begin
            m_r   <= {1'b0, m_r[108:2], m_r[1] | m_r[0]};
            exp_r <= exp_r + 14'sd1;
          end else if (!m_r[107] && exp_r > 14'sd1) begin
            m_r   <= {m_r[107:0], 1'b0};
            exp_r <= exp_r - 14'sd1;
          end else begin
            res_r   <= rnd_res;
            state_r <= F_DONE;
          end
        end
        F_DONE: begin
          done_r  <= 1'b1;
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign result   = res_r;

endmodule

[rtl/gaussian_product_binomial_coef_core.sv]
// Top level of the Gaussian product expansion coefficient core: sequencer
// around the shared binary64 unit. Depends on gpbc_pkg, gpbc_ifc, gpbc_fpu.
`timescale 1ns / 1ps

// One input beat is one Cartesian axis. The core returns the expansion
// coefficient f_k for that axis together with the running product of the
// coefficients of the current group, and it restores that product to one
// after a beat flagged as last axis. Every multiply and add runs on one
// shared binary64 unit. A multiply or add takes longer with every
// normalizing shift, and longer still for subnormal values or heavy
// cancellation, while one with an operand that is zero, infinite or NaN
// skips the arithmetic. A term costs (la-i)+(lb-k+i)+3 multiplies and,
// unless a momentum is zero, one add, which is up to la+lb-k+4 operations,
// and an axis has up to seven terms plus the final product multiply. For an
// order out of range the item is only that product multiply, which then
// sees a zero operand. The input is not ready while an item is at work. A
// finished result waits in an output register, and the core takes a new
// beat once that register is loaded.
module gaussian_product_binomial_coef_core import gpbc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gpbc_in_if.sink    in_ch,
  gpbc_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_POWA,
    S_POWB,
    S_TERM,
    S_CA,
    S_CB,
    S_SUM,
    S_ACC,
    S_OUT
  } state_t;

  state_t      state_r;
  logic        wait_r;
  logic [3:0]  k_r, cnt_r;
  logic [2:0]  la_r, lb_r, i_r, hi_r;
  logic [63:0] pa_r, pb_r, powa_r, powb_r, t_r, sum_r, f_r, acc_r, run_r;
  logic        last_r, single_r;

  logic        out_valid_r;
  logic [63:0] out_axis_r, out_run_r;
  logic        out_done_r;

  fpu_req_t    fpu_req;
  fpu_rsp_t    fpu_rsp;
  logic [63:0] fpu_a, fpu_b, fpu_res;

  gpbc_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fpu_req),
    .op_a   (fpu_a),
    .op_b   (fpu_b),
    .rsp    (fpu_rsp),
    .result (fpu_res)
  );

  // Momenta above the supported maximum saturate.
  logic [2:0] la_in, lb_in;
  assign la_in = (in_ch.momentum_a > 3'(MAX_MOMENTUM)) ? 3'(MAX_MOMENTUM) : in_ch.momentum_a;
  assign lb_in = (in_ch.momentum_b > 3'(MAX_MOMENTUM)) ? 3'(MAX_MOMENTUM) : in_ch.momentum_b;

  // Summation bounds of the current axis.
  logic [3:0] lo_w, hi_w, sum_ab;
  assign sum_ab = {1'b0, la_r} + {1'b0, lb_r};
  assign lo_w   = (k_r > {1'b0, lb_r}) ? (k_r - {1'b0, lb_r}) : 4'd0;
  assign hi_w   = (k_r < {1'b0, la_r}) ? k_r : {1'b0, la_r};

  logic [2:0] i_next;
  logic [2:0] kmi;
  assign i_next = i_r + 3'd1;
  assign kmi    = 3'(k_r - {1'b0, i_r});

  // Operand selection for the shared unit.
  logic issue;
  always_comb begin
    fpu_a = powa_r;
    fpu_b = pa_r;
    fpu_req.op = FOP_MUL;
    issue = 1'b0;
    case (state_r)
      S_POWA: begin fpu_a = powa_r; fpu_b = pa_r;   issue = (cnt_r != 4'd0); end
      S_POWB: begin fpu_a = powb_r; fpu_b = pb_r;   issue = (cnt_r != 4'd0); end
      S_TERM: begin fpu_a = powa_r; fpu_b = powb_r; issue = 1'b1; end
      S_CA:   begin fpu_a = t_r; fpu_b = binom_dbl(la_r, i_r); issue = 1'b1; end
      S_CB:   begin fpu_a = t_r; fpu_b = binom_dbl(lb_r, kmi);  issue = 1'b1; end
      S_SUM:  begin fpu_a = sum_r; fpu_b = t_r; fpu_req.op = FOP_ADD; issue = 1'b1; end
      S_ACC:  begin fpu_a = acc_r; fpu_b = f_r; issue = 1'b1; end
      default: issue = 1'b0;
    endcase
    fpu_req.start = issue && !wait_r;
  end

  logic out_take;
  assign out_take = out_valid_r && out_ch.ready;

  // The output register is loaded when it is empty or being drained.
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= DBL_ONE;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (fpu_req.start) begin
        wait_r <= 1'b1;
      end else if (fpu_rsp.done) begin
        wait_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            k_r     <= in_ch.order;
            la_r    <= la_in;
            lb_r    <= lb_in;
            pa_r    <= in_ch.dist_a;
            pb_r    <= in_ch.dist_b;
            last_r  <= in_ch.last_axis;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (k_r > sum_ab) begin
            // No index fits the bounds: the coefficient is plus zero.
            f_r     <= DBL_ZERO;
            state_r <= S_ACC;
          end else begin
            i_r      <= lo_w[2:0];
            hi_r     <= hi_w[2:0];
            single_r <= (la_r == 3'd0) || (lb_r == 3'd0);
            sum_r    <= DBL_ZERO;
            powa_r   <= DBL_ONE;
            cnt_r    <= {1'b0, la_r} - lo_w;
            state_r  <= S_POWA;
          end
        end
        S_POWA: begin
          if (!wait_r && cnt_r == 4'd0) begin
            powb_r  <= DBL_ONE;
            cnt_r   <= {1'b0, lb_r} - k_r + {1'b0, i_r};
            state_r <= S_POWB;
          end else if (wait_r && fpu_rsp.done) begin
            powa_r <= fpu_res;
            cnt_r  <= cnt_r - 4'd1;
          end
        end
        S_POWB: begin
          if (!wait_r && cnt_r == 4'd0) begin
            state_r <= S_TERM;
          end else if (wait_r && fpu_rsp.done) begin
            powb_r <= fpu_res;
            cnt_r  <= cnt_r - 4'd1;
          end
        end
        S_TERM: begin
          if (wait_r && fpu_rsp.done) begin
            t_r     <= fpu_res;
            state_r <= S_CA;
          end
        end
        S_CA: begin
          if (wait_r && fpu_rsp.done) begin
            t_r     <= fpu_res;
            state_r <= S_CB;
          end
        end
        S_CB: begin
          if (wait_r && fpu_rsp.done) begin
            if (single_r) begin
              // A single term is returned unchanged, so its zero sign holds.
              f_r     <= fpu_res;
              state_r <= S_ACC;
            end else begin
              t_r     <= fpu_res;
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (wait_r && fpu_rsp.done) begin
            if (i_r == hi_r) begin
              f_r     <= fpu_res;
              state_r <= S_ACC;
            end else begin
              sum_r   <= fpu_res;
              i_r     <= i_next;
              powa_r  <= DBL_ONE;
              cnt_r   <= {1'b0, la_r} - {1'b0, i_next};
              state_r <= S_POWA;
            end
          end
        end
        S_ACC: begin
          if (wait_r && fpu_rsp.done) begin
            run_r   <= fpu_res;
            acc_r   <= last_r ? DBL_ONE : fpu_res;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_axis_r  <= f_r;
            out_run_r   <= run_r;
            out_done_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.axis_coef    = out_axis_r;
  assign out_ch.running_coef = out_run_r;
  assign out_ch.group_done   = out_done_r;

`ifndef SYNTHESIS
  // The shared unit only answers an operation that was issued.
  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_rsp.done |-> wait_r)
    else $error("arithmetic unit finished with no operation pending");

  // An accepted beat closes the input until the item is finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready after a beat was accepted");

  // A new operation is never issued while one is outstanding.
  a_single_issue: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_req.start |-> !wait_r)
    else $error("second operation issued to a busy arithmetic unit");
`endif

endmodule
